[rtl/pfb_pkg.sv]
// Shared constants, types and the test pattern generator for the page frame buffer blitter.
// No dependencies; the top level refers to it by scoped names.
package pfb_pkg;

    localparam int SCREEN_WIDTH = 128;
    localparam int PAGE_COUNT   = 8;
    localparam int SCREEN_ROWS  = PAGE_COUNT * 8;
    localparam int STORE_BYTES  = SCREEN_WIDTH * PAGE_COUNT;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int COL_W  = $clog2(SCREEN_WIDTH);
    localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    // Corner mark extents, in columns
    localparam int CORNER_LEFT_SPAN  = 20;
    localparam int CORNER_RIGHT_SPAN = 11;

    localparam logic [2:0] ACT_BEGIN   = 3'd0;
    localparam logic [2:0] ACT_PIXELS  = 3'd1;
    localparam logic [2:0] ACT_CLEAR   = 3'd2;
    localparam logic [2:0] ACT_PATTERN = 3'd3;
    localparam logic [2:0] ACT_READ    = 3'd4;

    localparam logic [1:0] PAT_DIAGONAL = 2'd0;
    localparam logic [1:0] PAT_CHECKER  = 2'd1;
    localparam logic [1:0] PAT_INV_CHK  = 2'd2;
    localparam logic [1:0] PAT_CORNERS  = 2'd3;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [PAGE_W-1:0] page_t;

    // Byte of the selected test pattern at one page and column
    function automatic logic [7:0] pattern_byte(input logic [1:0] code, input page_t page,
                                                input col_t col);
        int         p;
        int         c;
        logic       odd;
        logic [7:0] corner;
        logic [7:0] v;
        p      = int'(page);
        c      = int'(col);
        odd    = ((c / 8) + (p % 2)) % 2 == 1;
        corner = 8'h00;
        if (p == 0)
        begin
            if (c == 0)                                    corner = 8'hFF;
            else if (c < CORNER_LEFT_SPAN)                 corner = 8'h01;
            else if (c == SCREEN_WIDTH - 1)                corner = 8'h0F;
            else if (c > SCREEN_WIDTH - CORNER_RIGHT_SPAN) corner = 8'h01;
        end
        // Bottom page marks win when there is only one page
        if (p == PAGE_COUNT - 1)
        begin
            if (c == 0)                                    corner = 8'h8F;
            else if (c < CORNER_LEFT_SPAN)                 corner = 8'h80;
            else if (c == SCREEN_WIDTH - 1)                corner = 8'hF0;
            else if (c > SCREEN_WIDTH - CORNER_RIGHT_SPAN) corner = 8'h80;
        end
        case (code)
            PAT_DIAGONAL: v = 8'(16'h0011 << col[2:0]);
            PAT_CHECKER:  v = odd ? 8'hFF : 8'h00;
            PAT_INV_CHK:  v = odd ? 8'h00 : 8'hFF;
            PAT_CORNERS:  v = corner;
            default:      v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

[rtl/page_framebuffer_blitter.sv]
// Page frame buffer blitter top level; uses pfb_pkg and pfb_ram.
// A begin word only loads the rectangle; a pixel word makes eight reads through the one
// read port, then the last write; clear and pattern fill write all STORE_BYTES bytes. After
// acceptance, a read result passes through the store's read register and out_data_reg. Words
// are taken one at a time (a pixel word also waits for its last write to land). Reset:
// asynchronous, active low; a clearing pass of the whole store follows, taking no word.
module page_framebuffer_blitter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] action,
    input  logic [7:0] rect_left,
    input  logic [7:0] rect_top,
    input  logic [7:0] rect_width,
    input  logic [7:0] rect_height,
    input  logic [7:0] pixel_bits,
    input  logic [1:0] pattern_code,
    input  logic [2:0] read_page,
    input  logic [6:0] read_column,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data
);

    typedef enum logic [2:0] {ST_INIT, ST_IDLE, ST_SWEEP, ST_PIXEL, ST_READ} state_t;

    localparam logic [15:0] INDEX_SAT  = 16'hFFFF;
    localparam logic [15:0] INDEX_LAST = 16'hFFF7;

    // Control state
    state_t         state_reg, state_next;
    pfb_pkg::page_t sw_page_reg, sw_page_next;
    pfb_pkg::col_t  sw_col_reg, sw_col_next;
    logic           sw_clear_reg, sw_clear_next;
    logic [1:0]     sw_code_reg, sw_code_next;
    logic [7:0]     clip_left_reg, clip_left_next;
    logic [7:0]     clip_top_reg, clip_top_next;
    logic [7:0]     clip_width_reg, clip_width_next;
    logic [15:0]    total_reg, total_next;
    logic [15:0]    index_reg, index_next;
    logic [7:0]     col_off_reg, col_off_next;
    logic [7:0]     row_off_reg, row_off_next;
    logic [2:0]     k_reg, k_next;
    logic           b_valid_reg, b_valid_next;
    logic           lw_valid_reg, lw_valid_next;
    logic           out_valid_reg, out_valid_next;

    // Payload
    logic [7:0]     bits_reg, bits_next;
    pfb_pkg::addr_t b_addr_reg, b_addr_next;
    logic [7:0]     b_mask_reg, b_mask_next;
    logic           b_on_reg, b_on_next;
    pfb_pkg::addr_t lw_addr_reg, lw_addr_next;
    logic [7:0]     lw_data_reg, lw_data_next;
    logic           rd_range_reg, rd_range_next;
    logic [7:0]     out_data_reg, out_data_next;

    // Memory port signals
    logic           ram_we;
    pfb_pkg::addr_t ram_waddr;
    logic [7:0]     ram_wdata;
    pfb_pkg::addr_t ram_raddr;
    logic [7:0]     ram_rdata;

    logic           accept;
    logic [16:0]    pix_idx;
    logic [8:0]     row_sum;
    logic [8:0]     col_sum;
    logic           pix_live;
    pfb_pkg::addr_t pix_addr;
    pfb_pkg::addr_t rd_addr;
    logic [7:0]     old_byte;
    logic [7:0]     new_byte;
    logic [7:0]     sweep_data;
    pfb_pkg::addr_t sweep_addr;
    logic           sweep_on;

    pfb_ram #(
        .WIDTH (8),
        .DEPTH (pfb_pkg::STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Take a word only when idle, no pixel write is still in flight, and the
    // result register will be free for a read.
    assign in_ready  = (state_reg == ST_IDLE) && !b_valid_reg && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;

    // Source pixel placement: the row and column offsets are stepped one pixel
    // at a time, so no divider is needed for index / width and index % width.
    assign pix_idx  = {1'b0, index_reg} + 17'(k_reg);
    assign row_sum  = 9'(clip_top_reg) + 9'(row_off_reg);
    assign col_sum  = 9'(clip_left_reg) + 9'(col_off_reg);
    assign pix_live = (pix_idx < {1'b0, total_reg}) && (clip_width_reg != 8'd0)
                      && (int'(row_sum) < pfb_pkg::SCREEN_ROWS)
                      && (int'(col_sum) < pfb_pkg::SCREEN_WIDTH);
    assign pix_addr = pfb_pkg::ADDR_W'(int'(row_sum[8:3]) * pfb_pkg::SCREEN_WIDTH
                                       + int'(col_sum));
    assign rd_addr  = pfb_pkg::ADDR_W'(int'(read_page) * pfb_pkg::SCREEN_WIDTH
                                       + int'(read_column));

    // Modify stage: forward the byte written last cycle, since the memory
    // returned the old contents when the read and that write coincided.
    assign old_byte = (lw_valid_reg && (lw_addr_reg == b_addr_reg)) ? lw_data_reg : ram_rdata;
    assign new_byte = b_on_reg ? (old_byte | b_mask_reg) : (old_byte & ~b_mask_reg);

    // Sweep for clear, pattern fill and the post-reset clearing pass
    assign sweep_on   = (state_reg == ST_INIT) || (state_reg == ST_SWEEP);
    assign sweep_addr = pfb_pkg::ADDR_W'(int'(sw_page_reg) * pfb_pkg::SCREEN_WIDTH
                                         + int'(sw_col_reg));
    assign sweep_data = sw_clear_reg ? 8'h00
                        : pfb_pkg::pattern_byte(sw_code_reg, sw_page_reg, sw_col_reg);

    // Pixel writes and sweeps never overlap: a sweep starts only once the
    // modify stage has drained.
    assign ram_we    = b_valid_reg || sweep_on;
    assign ram_waddr = b_valid_reg ? b_addr_reg : sweep_addr;
    assign ram_wdata = b_valid_reg ? new_byte : sweep_data;
    assign ram_raddr = (state_reg == ST_PIXEL) ? pix_addr : rd_addr;

    always_comb
    begin
        state_next      = state_reg;
        sw_page_next    = sw_page_reg;
        sw_col_next     = sw_col_reg;
        sw_clear_next   = sw_clear_reg;
        sw_code_next    = sw_code_reg;
        clip_left_next  = clip_left_reg;
        clip_top_next   = clip_top_reg;
        clip_width_next = clip_width_reg;
        total_next      = total_reg;
        index_next      = index_reg;
        col_off_next    = col_off_reg;
        row_off_next    = row_off_reg;
        k_next          = k_reg;
        bits_next       = bits_reg;
        b_valid_next    = 1'b0;
        b_addr_next     = b_addr_reg;
        b_mask_next     = b_mask_reg;
        b_on_next       = b_on_reg;
        lw_valid_next   = b_valid_reg;
        lw_addr_next    = b_addr_reg;
        lw_data_next    = new_byte;
        rd_range_next   = rd_range_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;

        case (state_reg)
            ST_INIT, ST_SWEEP:
            begin
                // Advance column, then page; drop back to idle after the last byte
                if (int'(sw_col_reg) == pfb_pkg::SCREEN_WIDTH - 1)
                begin
                    sw_col_next = '0;
                    if (int'(sw_page_reg) == pfb_pkg::PAGE_COUNT - 1)
                    begin
                        sw_page_next = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        sw_page_next = sw_page_reg + pfb_pkg::page_t'(1);
                    end
                end
                else
                begin
                    sw_col_next = sw_col_reg + pfb_pkg::col_t'(1);
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        pfb_pkg::ACT_BEGIN:
                        begin
                            clip_left_next  = rect_left;
                            clip_top_next   = rect_top;
                            clip_width_next = rect_width;
                            total_next      = 16'(rect_width) * 16'(rect_height);
                            index_next      = '0;
                            col_off_next    = '0;
                            row_off_next    = '0;
                        end
                        pfb_pkg::ACT_PIXELS:
                        begin
                            bits_next  = pixel_bits;
                            k_next     = '0;
                            state_next = ST_PIXEL;
                        end
                        pfb_pkg::ACT_CLEAR:
                        begin
                            sw_clear_next = 1'b1;
                            sw_page_next  = '0;
                            sw_col_next   = '0;
                            state_next    = ST_SWEEP;
                        end
                        pfb_pkg::ACT_PATTERN:
                        begin
                            sw_clear_next = 1'b0;
                            sw_code_next  = pattern_code;
                            sw_page_next  = '0;
                            sw_col_next   = '0;
                            state_next    = ST_SWEEP;
                        end
                        pfb_pkg::ACT_READ:
                        begin
                            rd_range_next = (int'(read_page) < pfb_pkg::PAGE_COUNT)
                                            && (int'(read_column) < pfb_pkg::SCREEN_WIDTH);
                            state_next    = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_PIXEL:
            begin
                // Issue the read for pixel k; its write happens next cycle
                b_valid_next = pix_live;
                b_addr_next  = pix_addr;
                b_mask_next  = 8'(9'd1 << row_sum[2:0]);
                b_on_next    = bits_reg[3'd7 - k_reg];
                if (9'(col_off_reg) + 9'd1 == 9'(clip_width_reg))
                begin
                    col_off_next = '0;
                    row_off_next = row_off_reg + 8'd1;
                end
                else
                begin
                    col_off_next = col_off_reg + 8'd1;
                end
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd7)
                begin
                    // Hold the source index at its ceiling rather than wrap
                    index_next = (index_reg > INDEX_LAST) ? INDEX_SAT : index_reg + 16'd8;
                    state_next = ST_IDLE;
                end
            end

            ST_READ:
            begin
                out_valid_next = 1'b1;
                out_data_next  = rd_range_reg ? ram_rdata : 8'h00;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            sw_page_reg    <= '0;
            sw_col_reg     <= '0;
            sw_clear_reg   <= 1'b1;
            sw_code_reg    <= '0;
            clip_left_reg  <= '0;
            clip_top_reg   <= '0;
            clip_width_reg <= '0;
            total_reg      <= '0;
            index_reg      <= '0;
            col_off_reg    <= '0;
            row_off_reg    <= '0;
            k_reg          <= '0;
            b_valid_reg    <= 1'b0;
            lw_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sw_page_reg    <= sw_page_next;
            sw_col_reg     <= sw_col_next;
            sw_clear_reg   <= sw_clear_next;
            sw_code_reg    <= sw_code_next;
            clip_left_reg  <= clip_left_next;
            clip_top_reg   <= clip_top_next;
            clip_width_reg <= clip_width_next;
            total_reg      <= total_next;
            index_reg      <= index_next;
            col_off_reg    <= col_off_next;
            row_off_reg    <= row_off_next;
            k_reg          <= k_next;
            b_valid_reg    <= b_valid_next;
            lw_valid_reg   <= lw_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg     <= bits_next;
        b_addr_reg   <= b_addr_next;
        b_mask_reg   <= b_mask_next;
        b_on_reg     <= b_on_next;
        lw_addr_reg  <= lw_addr_next;
        lw_data_reg  <= lw_data_next;
        rd_range_reg <= rd_range_next;
        out_data_reg <= out_data_next;
    end

endmodule

[rtl/pfb_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered read data.
// Read during write to the same entry returns the old contents. No dependencies.
module pfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
